>>> rtl/core/bacl_pkg.sv
// Shared types and constants for the block allocator with class lists.
package bacl_pkg;

    localparam int KIND_W    = 1;
    localparam int LEVEL_W   = 3;
    localparam int BLOCK_W   = 10;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam kind_t KIND_ALLOC   = 1'b0;
    localparam kind_t KIND_DISPOSE = 1'b1;

    localparam status_t STATUS_OK     = 2'd0;
    localparam status_t STATUS_EMPTY  = 2'd1;
    localparam status_t STATUS_HEADER = 2'd2;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_A_RD,
        ST_A_LINK,
        ST_A_PREV,
        ST_D_RD,
        ST_D_UNLINK,
        ST_D_FREE,
        ST_DONE
    } state_t;

endpackage

>>> rtl/core/block_allocator_with_class_lists.sv
// Top level of the block allocator with a free list and per-level block lists.
//
// Block 0 is the header and is never granted; link value 0 means "none". After
// reset the block runs a clearing pass that chains the free list and empties
// the level lists; s_tready stays low for that time. Each item then runs through
// a small sequencer around the link memories, which have one write and one
// registered read port each: an allocate steps through ST_A_RD, ST_A_LINK and
// ST_A_PREV, a dispose through ST_D_RD, ST_D_UNLINK and ST_D_FREE, and an
// empty-pool allocate, a header dispose or an out-of-range dispose goes from its
// read state straight to ST_DONE. The step order is set by the read-then-write
// order on the next_link and prev_link memories. A finished result waits in the
// output register while the block accepts the next item.
module block_allocator_with_class_lists #(
    parameter int NUM_BLOCKS = 1024,
    parameter int LEVELS     = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bacl_pkg::S_TDATA_W-1:0] s_tdata,   // level[2:0], block_index[12:3]
    input  logic [bacl_pkg::KIND_W-1:0]    s_tuser,   // kind[0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bacl_pkg::M_TDATA_W-1:0] m_tdata    // status[1:0], granted_block[11:2]
);

    import bacl_pkg::*;

    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int INIT_N = (NUM_BLOCKS > LEVELS) ? NUM_BLOCKS : LEVELS;
    localparam int CNT_W  = $clog2(INIT_N);
    localparam int WW     = 18;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] free_head_reg, free_head_next;
    logic [IDX_W-1:0] g_reg, g_next;
    logic [IDX_W-1:0] b_reg, b_next;
    logic             b_range_reg, b_range_next;
    logic             b_zero_reg, b_zero_next;
    logic [LW-1:0]    lvl_reg, lvl_next;
    kind_t            kind_reg, kind_next;
    status_t          res_status_reg, res_status_next;
    logic [IDX_W-1:0] res_block_reg, res_block_next;
    logic             m_tvalid_reg, m_tvalid_next;
    status_t          m_status_reg, m_status_next;
    logic [BLOCK_W-1:0] m_block_reg, m_block_next;

    // memory ports
    logic             nl_we, pl_we, lh_we, bl_we;
    logic [IDX_W-1:0] nl_waddr, nl_wdata, nl_raddr, nl_rdata;
    logic [IDX_W-1:0] pl_waddr, pl_wdata, pl_rdata;
    logic [LW-1:0]    lh_waddr;
    logic [IDX_W-1:0] lh_wdata, lh_rdata;
    logic [LW-1:0]    bl_wdata, bl_rdata;

    logic             s_fire;
    logic [WW-1:0]    cnt_wide, cnt_inc, s_blk_wide, g_wide;
    logic [LEVEL_W-1:0] s_level;
    logic [BLOCK_W-1:0] s_block;

    function automatic logic [LW-1:0] lvl_mod(input logic [6:0] v);
        logic [6:0] r;
        r = v;
        for (int i = 0; i < 8; i++) begin
            if (r >= 7'(LEVELS)) begin
                r = r - 7'(LEVELS);
            end
        end
        return r[LW-1:0];
    endfunction

    assign s_level    = s_tdata[LEVEL_W-1:0];
    assign s_block    = s_tdata[LEVEL_W+BLOCK_W-1:LEVEL_W];
    assign s_fire     = s_tvalid && s_tready;
    assign s_blk_wide = WW'(s_block);
    assign cnt_wide   = WW'(cnt_reg);
    assign cnt_inc    = cnt_wide + WW'(1);
    assign g_wide     = WW'(res_block_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - STATUS_W - BLOCK_W){1'b0}}, m_block_reg, m_status_reg};

    bacl_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BLOCKS)) u_next_link (
        .aclk(aclk), .we(nl_we), .waddr(nl_waddr), .wdata(nl_wdata),
        .raddr(nl_raddr), .rdata(nl_rdata)
    );

    bacl_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BLOCKS)) u_prev_link (
        .aclk(aclk), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
        .raddr(b_reg), .rdata(pl_rdata)
    );

    bacl_ram #(.WIDTH(LW), .DEPTH(NUM_BLOCKS)) u_block_level (
        .aclk(aclk), .we(bl_we), .waddr(g_reg), .wdata(bl_wdata),
        .raddr(b_reg), .rdata(bl_rdata)
    );

    bacl_ram #(.WIDTH(IDX_W), .DEPTH(LEVELS)) u_level_head (
        .aclk(aclk), .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
        .raddr(lvl_reg), .rdata(lh_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            free_head_reg <= IDX_W'(1);
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            free_head_reg <= free_head_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        g_reg          <= g_next;
        b_reg          <= b_next;
        b_range_reg    <= b_range_next;
        b_zero_reg     <= b_zero_next;
        lvl_reg        <= lvl_next;
        kind_reg       <= kind_next;
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        m_status_reg   <= m_status_next;
        m_block_reg    <= m_block_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (cnt_wide == WW'(INIT_N - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_tuser == KIND_DISPOSE) ? ST_D_RD : ST_A_RD;
                end
            end
            ST_A_RD: begin
                state_next = (free_head_reg == '0) ? ST_DONE : ST_A_LINK;
            end
            ST_A_LINK:   state_next = ST_A_PREV;
            ST_A_PREV:   state_next = ST_DONE;
            ST_D_RD: begin
                state_next = (b_zero_reg || !b_range_reg) ? ST_DONE : ST_D_UNLINK;
            end
            ST_D_UNLINK: state_next = ST_D_FREE;
            ST_D_FREE:   state_next = ST_DONE;
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_INIT;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        cnt_next        = cnt_reg;
        free_head_next  = free_head_reg;
        g_next          = g_reg;
        b_next          = b_reg;
        b_range_next    = b_range_reg;
        b_zero_next     = b_zero_reg;
        lvl_next        = lvl_reg;
        kind_next       = kind_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_status_next   = m_status_reg;
        m_block_next    = m_block_reg;

        nl_we    = 1'b0;
        nl_waddr = b_reg;
        nl_wdata = free_head_reg;
        nl_raddr = (kind_reg == KIND_ALLOC) ? free_head_reg : b_reg;
        pl_we    = 1'b0;
        pl_waddr = g_reg;
        pl_wdata = '0;
        lh_we    = 1'b0;
        lh_waddr = lvl_reg;
        lh_wdata = g_reg;
        bl_we    = 1'b0;
        bl_wdata = lvl_reg;

        unique case (state_reg)
            ST_INIT: begin
                // chain the free list and empty every level list
                cnt_next = cnt_inc[CNT_W-1:0];
                nl_we    = (cnt_wide < WW'(NUM_BLOCKS));
                nl_waddr = cnt_wide[IDX_W-1:0];
                nl_wdata = (cnt_inc < WW'(NUM_BLOCKS)) ? cnt_inc[IDX_W-1:0] : '0;
                lh_we    = (cnt_wide < WW'(LEVELS));
                lh_waddr = cnt_wide[LW-1:0];
                lh_wdata = '0;
            end
            ST_IDLE: begin
                if (s_fire) begin
                    kind_next    = s_tuser;
                    lvl_next     = lvl_mod(7'(s_level));
                    b_next       = s_blk_wide[IDX_W-1:0];
                    b_zero_next  = (s_block == '0);
                    b_range_next = (s_blk_wide < WW'(NUM_BLOCKS));
                end
            end
            ST_A_RD: begin
                g_next          = free_head_reg;
                res_block_next  = free_head_reg;
                res_status_next = (free_head_reg == '0) ? STATUS_EMPTY : STATUS_OK;
            end
            ST_A_LINK: begin
                bl_we          = 1'b1;
                free_head_next = nl_rdata;
                nl_we          = 1'b1;
                nl_waddr       = g_reg;
                nl_wdata       = lh_rdata;
                lh_we          = 1'b1;
                pl_we          = (lh_rdata != '0);
                pl_waddr       = lh_rdata;
                pl_wdata       = g_reg;
            end
            ST_A_PREV: begin
                // after the old head's back link, so a self link ends as none
                pl_we    = 1'b1;
                pl_waddr = g_reg;
                pl_wdata = '0;
            end
            ST_D_RD: begin
                res_block_next  = '0;
                res_status_next = b_zero_reg ? STATUS_HEADER : STATUS_OK;
            end
            ST_D_UNLINK: begin
                if (pl_rdata != '0) begin
                    nl_we    = 1'b1;
                    nl_waddr = pl_rdata;
                    nl_wdata = nl_rdata;
                end else begin
                    lh_we    = 1'b1;
                    lh_waddr = lvl_mod(7'(bl_rdata));
                    lh_wdata = nl_rdata;
                end
                pl_we    = (nl_rdata != '0);
                pl_waddr = nl_rdata;
                pl_wdata = pl_rdata;
            end
            ST_D_FREE: begin
                nl_we          = 1'b1;
                nl_waddr       = b_reg;
                nl_wdata       = free_head_reg;
                free_head_next = b_reg;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_block_next  = g_wide[BLOCK_W-1:0];
                end
            end
            default: begin
                cnt_next = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/bacl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bacl_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> verif/tb.sv
// Self-checking testbench for the block allocator with per-level block lists.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bacl_pkg::*;

    localparam int NUM_BLOCKS = 1024;
    localparam int LEVELS     = 8;
    localparam int LIMIT      = 400000;

    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [LEVEL_W-1:0] level_t;

    typedef struct packed {
        kind_t  kind;
        level_t level;
        block_t idx;
    } request_t;

    typedef struct packed {
        status_t status;
        block_t  granted;
    } answer_t;

    typedef struct packed {
        request_t rq;
        answer_t  want;
    } job_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    block_allocator_with_class_lists #(
        .NUM_BLOCKS(NUM_BLOCKS),
        .LEVELS    (LEVELS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Shadow of the pool: link memories, levels and list heads.
    block_t link_next [NUM_BLOCKS];
    block_t link_prev [NUM_BLOCKS];
    level_t block_lvl [NUM_BLOCKS];
    block_t free_top;
    block_t list_top  [LEVELS];

    job_t    job_queue[$];
    answer_t due_results[$];
    block_t  held[$];
    block_t  ever_held[$];

    int errors     = 0;
    int n_issued   = 0;
    int n_checked  = 0;
    int n_grant    = 0;
    int n_empty    = 0;
    int n_header   = 0;
    int n_dispose  = 0;
    int n_stray    = 0;
    int peak_held  = 0;
    int gap_left   = 0;
    int stall_left = 0;
    int cycle_cnt  = 0;
    int hold_cnt   = 0;
    logic src_calm = 1'b0;
    logic snk_calm = 1'b0;
    logic hold_rx  = 1'b0;
    job_t cur;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    task automatic report_mismatch(string msg);
        if (errors < 30) $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Advance the shadow pool by one request and return the answer it gives.
    function automatic answer_t pool_step(request_t rq);
        answer_t ans;
        block_t  g;
        block_t  old;
        block_t  p;
        block_t  n;
        ans.status  = STATUS_OK;
        ans.granted = '0;
        if (rq.kind == KIND_ALLOC) begin
            g = free_top;
            if (g == '0) begin
                ans.status = STATUS_EMPTY;
                return ans;
            end
            block_lvl[g] = rq.level;
            free_top = link_next[g];
            old = list_top[rq.level];
            link_next[g] = old;
            if (old != '0) link_prev[old] = g;
            link_prev[g] = '0;
            list_top[rq.level] = g;
            ans.granted = g;
        end else if (rq.idx == '0) begin
            ans.status = STATUS_HEADER;
        end else begin
            // a 10-bit index never reaches past the pool, so no range case here
            p = link_prev[rq.idx];
            n = link_next[rq.idx];
            if (p != '0) link_next[p] = n;
            else list_top[block_lvl[rq.idx]] = n;
            if (n != '0) link_prev[n] = p;
            link_next[rq.idx] = free_top;
            free_top = rq.idx;
        end
        return ans;
    endfunction

    // Queue one request for the driver, keep the held-block bookkeeping current.
    function automatic block_t queue_request(kind_t k, level_t lv, block_t b);
        job_t j;
        bit   seen;
        j.rq.kind  = k;
        j.rq.level = lv;
        j.rq.idx   = b;
        j.want     = pool_step(j.rq);
        job_queue.push_back(j);
        n_issued++;
        if (k == KIND_ALLOC) begin
            if (j.want.status == STATUS_EMPTY) begin
                n_empty++;
            end else begin
                n_grant++;
                held.push_back(j.want.granted);
                seen = 1'b0;
                foreach (ever_held[i]) begin
                    if (ever_held[i] == j.want.granted) seen = 1'b1;
                end
                if (!seen) ever_held.push_back(j.want.granted);
            end
        end else if (b == '0) begin
            n_header++;
        end else begin
            n_dispose++;
            foreach (held[i]) begin
                if (held[i] == b) begin
                    held.delete(i);
                    break;
                end
            end
        end
        if (held.size() > peak_held) peak_held = held.size();
        return j.want.granted;
    endfunction

    task automatic random_request(int alloc_pct);
        int r;
        int pick;
        r = $urandom_range(99);
        if (r < 3) begin
            void'(queue_request(KIND_DISPOSE, level_t'($urandom), '0));
        end else if (r == 3 && ever_held.size() > 0) begin
            // any block that was once granted, free or not: links are trusted as given
            pick = $urandom_range(ever_held.size() - 1);
            void'(queue_request(KIND_DISPOSE, level_t'($urandom), ever_held[pick]));
        end else if (held.size() == 0 || $urandom_range(99) < alloc_pct) begin
            void'(queue_request(KIND_ALLOC, level_t'($urandom), block_t'($urandom)));
        end else begin
            pick = $urandom_range(held.size() - 1);
            void'(queue_request(KIND_DISPOSE, level_t'($urandom), held[pick]));
        end
    endtask

    task automatic wait_drained();
        while (n_checked != n_issued) @(posedge aclk);
    endtask

    function automatic int draw_gap();
        int r;
        if (src_calm) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Stimulus and prediction.
    initial begin
        block_t g0;
        block_t g1;
        block_t g2;
        block_t g3;
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            link_next[i] = (i + 1 < NUM_BLOCKS) ? block_t'(i + 1) : '0;
            link_prev[i] = '0;
            block_lvl[i] = '0;
        end
        foreach (list_top[i]) list_top[i] = '0;
        free_top = block_t'(1);

        // three blocks on level 0, one each on levels 7 and 5
        g0 = queue_request(KIND_ALLOC, 3'd0, 10'h3FF);
        g1 = queue_request(KIND_ALLOC, 3'd0, 10'h000);
        g2 = queue_request(KIND_ALLOC, 3'd0, 10'h2AA);
        g3 = queue_request(KIND_ALLOC, 3'd7, 10'h155);
        void'(queue_request(KIND_ALLOC, 3'd5, 10'h3FF));
        // unlink from the middle, the head, the tail, then an only entry
        void'(queue_request(KIND_DISPOSE, 3'd7, g1));
        void'(queue_request(KIND_DISPOSE, 3'd0, g2));
        void'(queue_request(KIND_DISPOSE, 3'd5, g0));
        void'(queue_request(KIND_DISPOSE, 3'd2, g3));
        void'(queue_request(KIND_DISPOSE, 3'd7, 10'h000));
        void'(queue_request(KIND_DISPOSE, 3'd0, 10'h000));
        void'(queue_request(KIND_ALLOC, 3'd2, 10'h155));
        void'(queue_request(KIND_ALLOC, 3'd1, 10'h2AA));
        // g1 sits on the free list now: dispose it again anyway
        void'(queue_request(KIND_DISPOSE, 3'd6, g1));
        void'(queue_request(KIND_ALLOC, 3'd4, 10'h0F0));
        void'(queue_request(KIND_ALLOC, 3'd3, 10'h30F));

        repeat (300) random_request(55);

        // hold the sender until everything is back
        wait_drained();

        // run the pool dry, then ask a few more times
        repeat (NUM_BLOCKS - 1 - held.size() + 4)
            void'(queue_request(KIND_ALLOC, level_t'($urandom), block_t'($urandom)));

        repeat (230) random_request(35);

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Covered %0d items: %0d grants, %0d empty-pool answers, %0d disposes,",
                 n_issued, n_grant, n_empty, n_dispose);
        $display("%0d header refusals; at most %0d blocks held at once.", n_header, peak_held);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Driver: one item at a time from the job queue, random gaps between items.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                due_results.push_back(cur.want);
                gap_left = draw_gap();
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (job_queue.size() > 0) begin
                    cur = job_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, cur.rq.idx, cur.rq.level};
                    s_tuser  <= cur.rq.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest expectation, stall at random.
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    n_stray++;
                    report_mismatch($sformatf("unexpected result, tdata %h", m_tdata));
                end else begin
                    want = due_results.pop_front();
                    n_checked++;
                    if (m_tdata[1:0] != want.status)
                        report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                                  n_checked, m_tdata[1:0], want.status));
                    if (m_tdata[11:2] != want.granted)
                        report_mismatch($sformatf("result %0d: block %0d, expected %0d",
                                                  n_checked, m_tdata[11:2], want.granted));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!snk_calm && $urandom_range(99) < 25) begin
                stall_left = ($urandom_range(99) < 88) ? $urandom_range(2, 0)
                                                       : $urandom_range(40, 10);
                m_tready <= 1'b0;
            end else begin
                m_tready <= !hold_rx;
            end
        end
    end

    // Long receiver hold-offs so the block fills and stops taking items.
    always @(posedge aclk) begin
        hold_cnt <= hold_cnt + 1;
        hold_rx  <= (hold_cnt >= 1800 && hold_cnt < 2300) ||
                    (hold_cnt >= 7000 && hold_cnt < 7300);
    end

    // Cycle limit and switching between calm and gappy stretches.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 250 == 0) begin
            src_calm <= ($urandom_range(3) == 0);
            snk_calm <= ($urandom_range(3) == 0);
        end
        if (cycle_cnt == LIMIT) begin
            $display("Timeout after %0d cycles, %0d of %0d results seen",
                     cycle_cnt, n_checked, n_issued);
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

>>> filelist.f
rtl/core/bacl_pkg.sv
rtl/core/bacl_ram.sv
rtl/core/block_allocator_with_class_lists.sv
verif/tb.sv
